/* src/assert_macros.svh */
// Assertion macros shared by the stripe sector mapper RTL.
// Plain text macros only; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is low
`define SMAP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked assertion that is checked through reset as well
`define SMAP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/smap_pkg.sv */
// Shared types and constants of the stripe sector mapper.
// No dependencies; used by every module of the block except smap_ram.
package smap_pkg;

  // Field widths fixed by the interface
  localparam int CHUNK_BITS      = 32;
  localparam int COUNT_BITS      = 5;
  localparam int SHIFT_BITS      = 5;
  localparam int IDX_BITS        = 4;
  localparam int START_BITS      = 48;
  localparam int DEV_BITS        = 16;
  localparam int PHYS_BITS       = 48;
  localparam int IN_DATA_BITS    = 120;
  localparam int OUT_DATA_BITS   = 72;

  // Divider layout: quotient bits resolved per pipeline stage
  localparam int STEPS_PER_STAGE = 8;
  localparam int DIV_STAGES      = CHUNK_BITS / STEPS_PER_STAGE;

  // Configuration register indexes
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 48;
  localparam logic [CFG_ADDR_BITS-1:0] REG_BASE_SECTOR  = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_STRIPE_COUNT = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CHUNK_LOG2   = 2'd2;

  // Partial division: word holds remaining dividend bits and quotient bits
  typedef struct packed {
    logic [CHUNK_BITS-1:0] word;
    logic [COUNT_BITS-1:0] rem;
  } div_t;

  // Table load payload carried down the pipeline with each transaction
  typedef struct packed {
    logic                  is_load;
    logic [IDX_BITS-1:0]   idx;
    logic [START_BITS-1:0] start;
    logic [DEV_BITS-1:0]   dev;
  } load_t;

endpackage

/* src/stripe_sector_mapper_unit.sv */
// Top level of the striped sector mapper: configuration registers and the
// pipeline. Depends on smap_pkg, smap_front, smap_div_stage, smap_back, assert_macros.svh.
//
//   channel  dir  handshake           payload
//   in_      in   in_tvalid/tready    tuser: mode; tdata: sector, entry_index,
//                                     entry_start, entry_device
//   out_     out  out_tvalid/tready   tdata: device, physical_sector, stripe_index
//   cfg_     in   cfg_we              cfg_addr register index, cfg_wdata value
//
// One transaction per cycle while the output is not stalled; a map result passes
// through offset, chunk split, four divider stages of 8 quotient bits, table read
// and final sum. Load transactions write the table and leave no result.
// A stall holds each full stage; empty stages keep filling behind it.
// Synchronous reset clears the valid bits and sets base sector 0, stripe count 1
// and chunk log2 7; the stripe table holds no reset value and must be loaded before use.
`include "assert_macros.svh"

module stripe_sector_mapper_unit #(
  parameter int MAX_STRIPES = 16,
  parameter int SECTOR_BITS = 48
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [smap_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [smap_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [47:0] sector, [51:48] entry_index, [99:52] entry_start,
  // [115:100] entry_device, [119:116] zero
  input  logic [smap_pkg::IN_DATA_BITS-1:0]  in_tdata,
  // [0] mode
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [15:0] device, [63:16] physical_sector, [67:64] stripe_index, [71:68] zero
  output logic [smap_pkg::OUT_DATA_BITS-1:0] out_tdata
);

  localparam int CB     = smap_pkg::COUNT_BITS;
  localparam int NDIV   = smap_pkg::DIV_STAGES;
  localparam int SIDE_W = $bits(smap_pkg::load_t) + SECTOR_BITS;
  localparam int PAD_W  = smap_pkg::OUT_DATA_BITS - smap_pkg::DEV_BITS
                          - smap_pkg::PHYS_BITS - smap_pkg::IDX_BITS;

  logic [smap_pkg::START_BITS-1:0] base_sector_r;
  logic [CB-1:0]                   stripe_count_r;
  logic [smap_pkg::SHIFT_BITS-1:0] chunk_log2_r;
  logic [CB-1:0]                   eff_count;

  smap_pkg::load_t                 in_load;
  smap_pkg::load_t                 front_load;
  logic [SECTOR_BITS-1:0]          front_within;
  smap_pkg::load_t                 back_load;

  logic                            div_v   [NDIV+1];
  logic                            div_rdy [NDIV+1];
  smap_pkg::div_t                  div_d   [NDIV+1];
  logic [SIDE_W-1:0]               div_side[NDIV+1];

  logic [smap_pkg::DEV_BITS-1:0]   res_device;
  logic [smap_pkg::PHYS_BITS-1:0]  res_phys;
  logic [smap_pkg::IDX_BITS-1:0]   res_stripe;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_sector_r  <= '0;
      stripe_count_r <= CB'(1);
      chunk_log2_r   <= smap_pkg::SHIFT_BITS'(7);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        smap_pkg::REG_BASE_SECTOR:  base_sector_r  <= cfg_wdata;
        smap_pkg::REG_STRIPE_COUNT: stripe_count_r <= cfg_wdata[CB-1:0];
        smap_pkg::REG_CHUNK_LOG2:   chunk_log2_r   <= cfg_wdata[smap_pkg::SHIFT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Divisor: zero counts as one, large counts saturate to the table depth
  always_comb begin
    if (stripe_count_r == '0) begin
      eff_count = CB'(1);
    end else if (int'(stripe_count_r) > MAX_STRIPES) begin
      eff_count = CB'(MAX_STRIPES);
    end else begin
      eff_count = stripe_count_r;
    end
  end

  // Unpack the input transaction
  always_comb begin
    in_load.is_load = in_tuser;
    in_load.idx     = in_tdata[51:48];
    in_load.start   = in_tdata[99:52];
    in_load.dev     = in_tdata[115:100];
  end

  smap_front #(
    .SECTOR_BITS (SECTOR_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .base_sector (base_sector_r),
    .chunk_log2  (chunk_log2_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_sector   (in_tdata[47:0]),
    .in_load     (in_load),
    .out_valid   (div_v[0]),
    .out_ready   (div_rdy[0]),
    .out_load    (front_load),
    .out_div     (div_d[0]),
    .out_within  (front_within)
  );

  assign div_side[0] = {front_load, front_within};

  // Divider chain
  for (genvar g = 0; g < NDIV; g++) begin : g_div
    smap_div_stage #(
      .SIDE_W (SIDE_W)
    ) u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .divisor   (eff_count),
      .in_valid  (div_v[g]),
      .in_ready  (div_rdy[g]),
      .in_div    (div_d[g]),
      .in_side   (div_side[g]),
      .out_valid (div_v[g+1]),
      .out_ready (div_rdy[g+1]),
      .out_div   (div_d[g+1]),
      .out_side  (div_side[g+1])
    );
  end

  assign back_load = div_side[NDIV][SIDE_W-1:SECTOR_BITS];

  smap_back #(
    .MAX_STRIPES (MAX_STRIPES),
    .SECTOR_BITS (SECTOR_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .chunk_log2  (chunk_log2_r),
    .in_valid    (div_v[NDIV]),
    .in_ready    (div_rdy[NDIV]),
    .in_load     (back_load),
    .in_div      (div_d[NDIV]),
    .in_within   (div_side[NDIV][SECTOR_BITS-1:0]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_device  (res_device),
    .out_phys    (res_phys),
    .out_stripe  (res_stripe)
  );

  assign out_tdata = {{PAD_W{1'b0}}, res_stripe, res_phys, res_device};

  // Back-pressure can only start at the output register
  `SMAP_ASSERT(a_stall_origin, clk, rst_n, !in_tready |-> (out_tvalid && !out_tready), "input stalled without an output stall")
  // A transaction held at the divider exit is not dropped
  `SMAP_ASSERT(a_div_exit_hold, clk, rst_n, (div_v[NDIV] && !div_rdy[NDIV]) |=> div_v[NDIV], "divider exit lost a transaction")
  // The front stages hold their partial quotient while stalled
  `SMAP_ASSERT(a_front_hold, clk, rst_n, (div_v[0] && !div_rdy[0]) |=> (div_v[0] && $stable(div_d[0])), "front stage changed while stalled")

endmodule

/* src/smap_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smap_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/smap_front.sv */
// Front stages: offset from the logical start, then chunk number and
// offset within the chunk. Depends on smap_pkg.
module smap_front #(
  parameter int SECTOR_BITS = 48
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [smap_pkg::START_BITS-1:0]     base_sector,
  input  logic [smap_pkg::SHIFT_BITS-1:0]     chunk_log2,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [smap_pkg::START_BITS-1:0]     in_sector,
  input  smap_pkg::load_t                     in_load,
  output logic                                out_valid,
  input  logic                                out_ready,
  output smap_pkg::load_t                     out_load,
  output smap_pkg::div_t                      out_div,
  output logic [SECTOR_BITS-1:0]              out_within
);

  logic                   s1_v_r;
  smap_pkg::load_t        s1_load_r;
  logic [SECTOR_BITS-1:0] s1_off_r;
  logic [SECTOR_BITS-1:0] off_nxt;
  logic                   s1_rdy;

  logic                   s2_v_r;
  smap_pkg::load_t        s2_load_r;
  smap_pkg::div_t         s2_div_r;
  logic [SECTOR_BITS-1:0] s2_within_r;
  smap_pkg::div_t         div_nxt;
  logic [SECTOR_BITS-1:0] within_nxt;
  logic                   s2_rdy;

  // Advance a stage when it is empty or its successor takes its item
  assign s2_rdy   = !s2_v_r || out_ready;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;

  // Offset wraps modulo the sector width
  assign off_nxt = SECTOR_BITS'(in_sector) - SECTOR_BITS'(base_sector);

  // Split offset into chunk number and position inside the chunk
  always_comb begin
    div_nxt.word = smap_pkg::CHUNK_BITS'(s1_off_r >> chunk_log2);
    div_nxt.rem  = '0;
    within_nxt   = s1_off_r & ~({SECTOR_BITS{1'b1}} << chunk_log2);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_r <= in_valid;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  // Payload, held while a stage stalls
  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_load_r <= in_load;
      s1_off_r  <= off_nxt;
    end
    if (s2_rdy) begin
      s2_load_r   <= s1_load_r;
      s2_div_r    <= div_nxt;
      s2_within_r <= within_nxt;
    end
  end

  assign out_valid  = s2_v_r;
  assign out_load   = s2_load_r;
  assign out_div    = s2_div_r;
  assign out_within = s2_within_r;

endmodule

/* src/smap_div_stage.sv */
// One divider stage: resolves a group of quotient bits of the chunk number
// by restoring division against the stripe count. Depends on smap_pkg.
module smap_div_stage #(
  parameter int SIDE_W = 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [smap_pkg::COUNT_BITS-1:0] divisor,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  smap_pkg::div_t                  in_div,
  input  logic [SIDE_W-1:0]               in_side,
  output logic                            out_valid,
  input  logic                            out_ready,
  output smap_pkg::div_t                  out_div,
  output logic [SIDE_W-1:0]               out_side
);

  // Shift-subtract steps; the remainder stays below the divisor
  function automatic smap_pkg::div_t div_steps(input smap_pkg::div_t d,
                                               input logic [smap_pkg::COUNT_BITS-1:0] dv);
    smap_pkg::div_t                acc;
    logic [smap_pkg::COUNT_BITS:0] trial;
    acc = d;
    for (int i = 0; i < smap_pkg::STEPS_PER_STAGE; i++) begin
      trial    = {acc.rem, acc.word[smap_pkg::CHUNK_BITS-1]};
      acc.word = {acc.word[smap_pkg::CHUNK_BITS-2:0], 1'b0};
      if (trial >= {1'b0, dv}) begin
        trial       = trial - {1'b0, dv};
        acc.word[0] = 1'b1;
      end
      acc.rem = trial[smap_pkg::COUNT_BITS-1:0];
    end
    return acc;
  endfunction

  logic              v_r;
  smap_pkg::div_t    div_r;
  logic [SIDE_W-1:0] side_r;
  logic              rdy;

  assign rdy      = !v_r || out_ready;
  assign in_ready = rdy;

  // Valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= in_valid;
    end
  end

  // Payload, held while stalled
  always_ff @(posedge clk) begin
    if (rdy) begin
      div_r  <= div_steps(in_div, divisor);
      side_r <= in_side;
    end
  end

  assign out_valid = v_r;
  assign out_div   = div_r;
  assign out_side  = side_r;

endmodule

/* src/smap_back.sv */
// Back stages: stripe table access (load writes, map reads) and the
// physical sector sum into the output register. Depends on smap_pkg, smap_ram.
module smap_back #(
  parameter int MAX_STRIPES = 16,
  parameter int SECTOR_BITS = 48
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [smap_pkg::SHIFT_BITS-1:0] chunk_log2,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  smap_pkg::load_t                 in_load,
  input  smap_pkg::div_t                  in_div,
  input  logic [SECTOR_BITS-1:0]          in_within,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [smap_pkg::DEV_BITS-1:0]   out_device,
  output logic [smap_pkg::PHYS_BITS-1:0]  out_phys,
  output logic [smap_pkg::IDX_BITS-1:0]   out_stripe
);

  localparam int AW    = (MAX_STRIPES > 1) ? $clog2(MAX_STRIPES) : 1;
  localparam int ENT_W = smap_pkg::START_BITS + smap_pkg::DEV_BITS;

  logic                            take;
  logic                            map_take;
  logic                            tbl_we;
  logic [ENT_W-1:0]                tbl_rdata;
  logic [SECTOR_BITS-1:0]          rowsh_nxt;
  logic [SECTOR_BITS-1:0]          phys_nxt;

  logic                            s7_v_r;
  logic [SECTOR_BITS-1:0]          s7_rowsh_r;
  logic [smap_pkg::COUNT_BITS-1:0] s7_stripe_r;
  logic                            s7_rdy;

  logic                            out_v_r;
  logic [smap_pkg::DEV_BITS-1:0]   out_dev_r;
  logic [smap_pkg::PHYS_BITS-1:0]  out_phys_r;
  logic [smap_pkg::IDX_BITS-1:0]   out_stripe_r;
  logic                            s8_rdy;

  assign s8_rdy   = !out_v_r || out_ready;
  assign s7_rdy   = !s7_v_r || s8_rdy;
  assign in_ready = s7_rdy;

  // Loads write the table as they pass; maps read it in the same position
  assign take     = in_valid && s7_rdy;
  assign map_take = take && !in_load.is_load;
  assign tbl_we   = take && in_load.is_load && (int'(in_load.idx) < MAX_STRIPES);

  smap_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_STRIPES)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(in_load.idx)),
    .wdata ({in_load.start, in_load.dev}),
    .re    (map_take),
    .raddr (AW'(in_div.rem)),
    .rdata (tbl_rdata)
  );

  // Quotient shifted into place; the chunk offset fills the low bits
  assign rowsh_nxt = (SECTOR_BITS'(in_div.word) << chunk_log2) | in_within;

  // Stripe start plus position on the device
  assign phys_nxt = SECTOR_BITS'(tbl_rdata[ENT_W-1:smap_pkg::DEV_BITS]) + s7_rowsh_r;

  // Valid bits; load transactions end here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s7_rdy) begin
        s7_v_r <= in_valid && !in_load.is_load;
      end
      if (s8_rdy) begin
        out_v_r <= s7_v_r;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (map_take) begin
      s7_rowsh_r  <= rowsh_nxt;
      s7_stripe_r <= in_div.rem;
    end
    if (s8_rdy && s7_v_r) begin
      out_dev_r    <= tbl_rdata[smap_pkg::DEV_BITS-1:0];
      out_phys_r   <= smap_pkg::PHYS_BITS'(phys_nxt);
      out_stripe_r <= smap_pkg::IDX_BITS'(s7_stripe_r);
    end
  end

  assign out_valid  = out_v_r;
  assign out_device = out_dev_r;
  assign out_phys   = out_phys_r;
  assign out_stripe = out_stripe_r;

endmodule
